/* rtl/agmm_pkg.sv */
// Shared types, constants and rounding helper for the gain matrix mixer.
`default_nettype none

package agmm_pkg;

    localparam int NUM_IN   = 4;
    localparam int NUM_OUT  = 4;
    localparam int IDX_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    // four Q3.29 products plus sign headroom
    localparam int ACC_W    = PROD_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 16;

    localparam logic [1:0] FUNC_SAMPLE      = 2'd0;
    localparam logic [1:0] FUNC_SET_INPLACE = 2'd1;
    localparam logic [1:0] FUNC_SET_CROSS   = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_UPDATED = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MASK   = 1'd1;

    localparam logic [GAIN_W-1:0] DEFAULT_GAIN_RST = 16'd16384;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [IDX_W-1:0]           idx_t;

    typedef struct packed {
        logic [1:0] func;
        sample_t    sample_0;
        sample_t    sample_1;
        sample_t    sample_2;
        sample_t    sample_3;
        idx_t       src_index;
        idx_t       dst_index;
        gain_t      new_gain;
    } in_item_t;

    typedef struct packed {
        sample_t    scaled_0;
        sample_t    scaled_1;
        sample_t    scaled_2;
        sample_t    scaled_3;
        sample_t    mix_0;
        sample_t    mix_1;
        sample_t    mix_2;
        sample_t    mix_3;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAT,
        ST_MIX,
        ST_MIX_LAST,
        ST_DONE
    } state_t;

    // Sequencer to lane control bundle
    typedef struct packed {
        logic  start;
        logic  sat;
        logic  mix_mul;
        logic  mix_add;
        logic  clear;
        idx_t  step;
        idx_t  src;
        gain_t gain;
        gain_t default_gain;
    } lane_ctl_t;

    // Q14 round half up (floor of x + 0.5), then clamp to 16 bits
    function automatic sample_t round_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] r;
        half = ACC_W'(1) <<< (FRAC_W - 1);
        hi   = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
        lo   = {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
        r    = (x + half) >>> FRAC_W;
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/agmm_scale_lane.sv */
// One input lane: in-place gain store, gain multiply, round and saturate.
`default_nettype none

module agmm_scale_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire agmm_pkg::lane_ctl_t ctl,
    input  wire logic                wr_en,
    input  wire agmm_pkg::sample_t   sample,
    output agmm_pkg::sample_t        scaled
);
    import agmm_pkg::*;

    gain_t                    gain_reg;
    logic                     written_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t                  scaled_reg;
    gain_t                    gain_eff;

    assign gain_eff = written_reg ? gain_reg : ctl.default_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            written_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gain_reg <= ctl.gain;
        end
        if (ctl.start)
        begin
            prod_reg <= sample * $signed({1'b0, gain_eff});
        end
        if (ctl.sat)
        begin
            scaled_reg <= round_sat(ACC_W'(prod_reg));
        end
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

/* rtl/agmm_mix_lane.sv */
// One output lane: crosspoint gains for this output, multiply-accumulate over inputs.
`default_nettype none

module agmm_mix_lane (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire agmm_pkg::lane_ctl_t                    ctl,
    input  wire logic                                   wr_en,
    input  wire logic [agmm_pkg::NUM_IN-1:0]            route,
    input  wire agmm_pkg::sample_t [agmm_pkg::NUM_IN-1:0] scaled_vec,
    output logic signed [agmm_pkg::ACC_W-1:0]           acc
);
    import agmm_pkg::*;

    gain_t                    gain_reg [NUM_IN];
    logic [NUM_IN-1:0]        written_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    gain_t                    gain_eff;
    logic signed [ACC_W-1:0]  acc_base;

    assign gain_eff = written_reg[ctl.step] ? gain_reg[ctl.step] : ctl.default_gain;
    assign acc_base = ctl.clear ? '0 : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[ctl.src] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gain_reg[ctl.src] <= ctl.gain;
        end
        if (ctl.mix_mul)
        begin
            // unrouted crosspoint adds nothing
            if (route[ctl.step])
            begin
                prod_reg <= $signed(scaled_vec[ctl.step]) * $signed({1'b0, gain_eff});
            end
            else
            begin
                prod_reg <= '0;
            end
        end
        if (ctl.mix_add)
        begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* rtl/audio_gain_matrix_mixer_top.sv */
// Top level: config registers, sequencer, scale and mix lanes, merge and output register.
`default_nettype none

// A sample transaction, from acceptance, runs the input multiply, saturate, four
// MAC steps, last add and output load; a command goes straight to the output load.
// A new item is taken only once the last one has loaded the output register; each
// output lane runs a four-step MAC sweep over the inputs.
// Reset: asynchronous, active low; config returns to default_gain 16384 and an
// empty route mask, all gains read as default, output register empties.
module audio_gain_matrix_mixer_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire agmm_pkg::in_item_t                  item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output agmm_pkg::out_item_t                      result,
    input  wire logic                                cfg_we,
    input  wire logic [agmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [agmm_pkg::CFG_W-1:0]          cfg_data
);
    import agmm_pkg::*;

    // ---------------- configuration registers ----------------
    gain_t                        default_gain_reg;
    logic [NUM_IN*NUM_OUT-1:0]    route_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_gain_reg <= DEFAULT_GAIN_RST;
            route_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEFAULT_GAIN: default_gain_reg <= cfg_data;
                REG_ROUTE_MASK:   route_mask_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    logic       item_accept;
    logic       xp_routed;
    logic [1:0] cmd_status;

    assign item_accept = item_valid && !item_stall;
    // crosspoint bit is input*NUM_OUT + output
    assign xp_routed   = route_mask_reg[{item.src_index, item.dst_index}];

    always_comb
    begin
        unique case (item.func)
            FUNC_SAMPLE:      cmd_status = STAT_DONE;
            FUNC_SET_INPLACE: cmd_status = STAT_UPDATED;
            FUNC_SET_CROSS:   cmd_status = xp_routed ? STAT_UPDATED : STAT_INVALID;
            default:          cmd_status = STAT_INVALID;
        endcase
    end

    // per-lane gain write strobes, taken at the accepting edge
    logic [NUM_IN-1:0]  wr_inplace;
    logic [NUM_OUT-1:0] wr_cross;

    always_comb
    begin
        wr_inplace = '0;
        wr_cross   = '0;
        if (item_accept && item.func == FUNC_SET_INPLACE)
        begin
            wr_inplace[item.src_index] = 1'b1;
        end
        if (item_accept && item.func == FUNC_SET_CROSS && xp_routed)
        begin
            wr_cross[item.dst_index] = 1'b1;
        end
    end

    // ---------------- sequencer ----------------
    state_t     state_reg, state_next;
    idx_t       step_reg, step_next;
    logic       is_sample_reg;
    logic [1:0] status_reg;
    logic       out_load;
    lane_ctl_t  ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            is_sample_reg <= 1'b0;
            status_reg    <= STAT_DONE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (item_accept)
            begin
                is_sample_reg <= (item.func == FUNC_SAMPLE);
                status_reg    <= cmd_status;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        item_stall       = 1'b1;
        out_load         = 1'b0;
        ctl.start        = 1'b0;
        ctl.sat          = 1'b0;
        ctl.mix_mul      = 1'b0;
        ctl.mix_add      = 1'b0;
        ctl.clear        = 1'b0;
        ctl.step         = step_reg;
        ctl.src          = item.src_index;
        ctl.gain         = item.new_gain;
        ctl.default_gain = default_gain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (item.func == FUNC_SAMPLE)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_SAT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SAT:
            begin
                ctl.sat    = 1'b1;
                step_next  = '0;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                // multiply for this step, add the product of the step before
                ctl.mix_mul = 1'b1;
                ctl.mix_add = (step_reg != '0);
                ctl.clear   = (step_reg == idx_t'(1));
                if (step_reg == idx_t'(NUM_IN - 1))
                begin
                    step_next  = '0;
                    state_next = ST_MIX_LAST;
                end
                else
                begin
                    step_next = step_reg + idx_t'(1);
                end
            end
            ST_MIX_LAST:
            begin
                ctl.mix_add = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- lanes ----------------
    sample_t [NUM_IN-1:0]          scaled_vec;
    logic signed [ACC_W-1:0]       acc_vec [NUM_OUT];
    sample_t                       sample_in [NUM_IN];

    assign sample_in[0] = item.sample_0;
    assign sample_in[1] = item.sample_1;
    assign sample_in[2] = item.sample_2;
    assign sample_in[3] = item.sample_3;

    genvar gi, go;
    generate
        for (gi = 0; gi < NUM_IN; gi++)
        begin : g_scale
            agmm_scale_lane u_scale (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .wr_en  (wr_inplace[gi]),
                .sample (sample_in[gi]),
                .scaled (scaled_vec[gi])
            );
        end
        for (go = 0; go < NUM_OUT; go++)
        begin : g_mix
            logic [NUM_IN-1:0] route;
            for (gi = 0; gi < NUM_IN; gi++)
            begin : g_route
                assign route[gi] = route_mask_reg[gi*NUM_OUT + go];
            end
            agmm_mix_lane u_mix (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .wr_en      (wr_cross[go]),
                .route      (route),
                .scaled_vec (scaled_vec),
                .acc        (acc_vec[go])
            );
        end
    endgenerate

    // ---------------- merge and output register ----------------
    out_item_t merged;
    out_item_t result_reg;
    logic      result_valid_reg;

    always_comb
    begin
        merged        = '0;
        merged.status = status_reg;
        if (is_sample_reg)
        begin
            merged.scaled_0 = scaled_vec[0];
            merged.scaled_1 = scaled_vec[1];
            merged.scaled_2 = scaled_vec[2];
            merged.scaled_3 = scaled_vec[3];
            merged.mix_0    = round_sat(acc_vec[0]);
            merged.mix_1    = round_sat(acc_vec[1]);
            merged.mix_2    = round_sat(acc_vec[2]);
            merged.mix_3    = round_sat(acc_vec[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= merged;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // never overwrite a result that is still held by a stall
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !out_load)
        else $error("result overwritten while stalled");

    // a sample transaction goes straight to the saturate step
    a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.func == FUNC_SAMPLE) |=> (state_reg == ST_SAT))
        else $error("sample did not start scaling");

    // commands reach the done state in the cycle after acceptance
    a_cmd_short: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.func != FUNC_SAMPLE) |=> (state_reg == ST_DONE))
        else $error("command did not complete");

    // the MAC step counter rests at zero outside the sweep
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MIX) |-> (step_reg == '0))
        else $error("step counter not parked");
`endif

endmodule

`default_nettype wire

/* test/tb_audio_gain_matrix_mixer_top.sv */
// Self-checking testbench for the audio gain matrix mixer top level.
`timescale 1ns / 100ps

module tb_audio_gain_matrix_mixer_top;
    import agmm_pkg::*;

    // func code the block must refuse without touching any gain
    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 9;
    // settle time after the last result before touching registers or ending
    localparam int SETTLE     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_SETTING = 305;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    audio_gain_matrix_mixer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Gain matrix predictor: shadow copy of registers and gain stores
    // ------------------------------------------------------------------
    gain_t              gm_default = DEFAULT_GAIN_RST;
    logic [15:0]        gm_routes = '0;
    gain_t              gm_inplace [NUM_IN];
    logic [NUM_IN-1:0]  gm_inplace_set = '0;
    gain_t              gm_cross [NUM_IN*NUM_OUT];
    logic [15:0]        gm_cross_set = '0;

    in_item_t  pending_items [$];
    out_item_t expected_mix [$];

    int err_count = 0;
    int cycle_count = 0;
    int n_done = 0;
    int n_updated = 0;
    int n_refused = 0;
    int n_settings = 0;

    // Q3.29 -> Q1.15: add half an LSB, floor, clamp to 16 bits
    function automatic sample_t q14_round_sat(input longint x);
        longint r;
        r = (x + 64'sd8192) >>> 14;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return sample_t'(r);
    endfunction

    // Works out the result of one transaction and applies its side effects
    function automatic out_item_t mixer_predict(input in_item_t it);
        out_item_t r;
        sample_t   smp [NUM_IN];
        sample_t   scl [NUM_IN];
        sample_t   mx [NUM_OUT];
        longint    acc;
        gain_t     g;
        int        x;
        r = '0;
        smp[0] = it.sample_0;
        smp[1] = it.sample_1;
        smp[2] = it.sample_2;
        smp[3] = it.sample_3;
        case (it.func)
            FUNC_SAMPLE:
            begin
                for (int i = 0; i < NUM_IN; i++)
                begin
                    g = gm_inplace_set[i] ? gm_inplace[i] : gm_default;
                    scl[i] = q14_round_sat(longint'(smp[i]) * longint'(g));
                end
                for (int o = 0; o < NUM_OUT; o++)
                begin
                    acc = 0;
                    for (int i = 0; i < NUM_IN; i++)
                    begin
                        x = i * NUM_OUT + o;
                        if (gm_routes[x])
                        begin
                            g = gm_cross_set[x] ? gm_cross[x] : gm_default;
                            acc += longint'(scl[i]) * longint'(g);
                        end
                    end
                    mx[o] = q14_round_sat(acc);
                end
                r.scaled_0 = scl[0];
                r.scaled_1 = scl[1];
                r.scaled_2 = scl[2];
                r.scaled_3 = scl[3];
                r.mix_0    = mx[0];
                r.mix_1    = mx[1];
                r.mix_2    = mx[2];
                r.mix_3    = mx[3];
                r.status   = STAT_DONE;
            end
            FUNC_SET_INPLACE:
            begin
                gm_inplace[it.src_index] = it.new_gain;
                gm_inplace_set[it.src_index] = 1'b1;
                r.status = STAT_UPDATED;
            end
            FUNC_SET_CROSS:
            begin
                x = it.src_index * NUM_OUT + it.dst_index;
                if (gm_routes[x])
                begin
                    gm_cross[x] = it.new_gain;
                    gm_cross_set[x] = 1'b1;
                    r.status = STAT_UPDATED;
                end
                else
                begin
                    r.status = STAT_INVALID;
                end
            end
            default:
                r.status = STAT_INVALID;
        endcase
        return r;
    endfunction

    // Field-by-field compare, one line per wrong field
    task automatic compare_mix(input out_item_t got, input out_item_t want);
        sample_t g_f [8];
        sample_t w_f [8];
        string   names [8];
        g_f = '{got.scaled_0, got.scaled_1, got.scaled_2, got.scaled_3,
                got.mix_0, got.mix_1, got.mix_2, got.mix_3};
        w_f = '{want.scaled_0, want.scaled_1, want.scaled_2, want.scaled_3,
                want.mix_0, want.mix_1, want.mix_2, want.mix_3};
        names = '{"scaled_0", "scaled_1", "scaled_2", "scaled_3",
                  "mix_0", "mix_1", "mix_2", "mix_3"};
        for (int k = 0; k < 8; k++)
        begin
            if (g_f[k] !== w_f[k])
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, names[k], w_f[k], g_f[k]);
                err_count++;
            end
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: accepted transactions and register writes feed the
    // predictor; sampled at the edge, before any driver update lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEFAULT_GAIN)
                    gm_default <= cfg_data;
                else if (cfg_index == REG_ROUTE_MASK)
                    gm_routes <= cfg_data;
            end
            if (item_valid && !item_stall)
                expected_mix.push_back(mixer_predict(item));
        end
    end

    // ------------------------------------------------------------------
    // Driver: pops pending items, leaving a random idle gap after each one,
    // with occasional stretches of back-to-back traffic.
    // ------------------------------------------------------------------
    int   send_gap = 0;
    logic send_idle = 1'b1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (send_gap != 0)
            begin
                send_gap   <= send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_idle <= ~send_idle;
                send_gap   <= send_idle ? $urandom_range(0, 3) : 0;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation,
    // then may stall for a random hold before taking the next one.
    // ------------------------------------------------------------------
    int   hold_cnt = 0;
    logic recv_idle = 1'b1;
    int   hold_draw;
    out_item_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (expected_mix.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                err_count++;
            end
            else
            begin
                want = expected_mix.pop_front();
                compare_mix(result, want);
                case (want.status)
                    STAT_DONE:    n_done++;
                    STAT_UPDATED: n_updated++;
                    default:      n_refused++;
                endcase
            end
            if ($urandom_range(0, 39) == 0)
                recv_idle <= ~recv_idle;
            hold_draw = recv_idle ? $urandom_range(0, 3) : 0;
            hold_cnt     <= hold_draw;
            result_stall <= (hold_draw != 0);
        end
        else if (hold_cnt > 1)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else
        begin
            hold_cnt     <= 0;
            result_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_mix.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t sample_item(input sample_t a, input sample_t b,
                                             input sample_t c, input sample_t d);
        in_item_t it;
        it = '0;
        it.func     = FUNC_SAMPLE;
        it.sample_0 = a;
        it.sample_1 = b;
        it.sample_2 = c;
        it.sample_3 = d;
        return it;
    endfunction

    function automatic in_item_t gain_cmd(input logic [1:0] f, input idx_t src,
                                          input idx_t dst, input gain_t g);
        in_item_t it;
        it = '0;
        it.func      = f;
        it.src_index = src;
        it.dst_index = dst;
        it.new_gain  = g;
        return it;
    endfunction

    // Full-scale values show up often so the saturation paths get exercised
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return sample_t'($urandom_range(0, 3)) - 16'sd1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic gain_t rand_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h4000;
            3:       return gain_t'($urandom_range(0, 16'h4000));
            default: return gain_t'($urandom);
        endcase
    endfunction

    // Mostly sample positions, a steady stream of gain commands, rare noise
    function automatic in_item_t rand_item();
        in_item_t it;
        int       pick;
        it.sample_0  = rand_sample();
        it.sample_1  = rand_sample();
        it.sample_2  = rand_sample();
        it.sample_3  = rand_sample();
        it.src_index = idx_t'($urandom);
        it.dst_index = idx_t'($urandom);
        it.new_gain  = rand_gain();
        pick = $urandom_range(0, 99);
        if (pick < 62)
            it.func = FUNC_SAMPLE;
        else if (pick < 72)
            it.func = FUNC_SET_INPLACE;
        else if (pick < 95)
            it.func = FUNC_SET_CROSS;
        else
            it.func = FUNC_RESERVED;
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Registers only change once the block has gone quiet
    task automatic wait_quiet();
        while (pending_items.size() != 0 || item_valid || expected_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic new_setting(input gain_t dflt, input logic [15:0] routes);
        wait_quiet();
        write_reg(REG_DEFAULT_GAIN, dflt);
        write_reg(REG_ROUTE_MASK, routes);
        n_settings++;
    endtask

    task automatic random_burst(input int count);
        for (int k = 0; k < count; k++)
            pending_items.push_back(rand_item());
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        n_settings = 1;

        // Reset settings: unity default gain, nothing routed
        pending_items.push_back(sample_item(16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1));
        pending_items.push_back(sample_item(16'sd1, -16'sd1, 16'sd16384, -16'sd16384));
        // crosspoint command on an unrouted pair is refused
        pending_items.push_back(gain_cmd(FUNC_SET_CROSS, 2'd3, 2'd3, 16'hFFFF));
        // reserved func: ignored, zero fields, invalid status
        begin
            in_item_t junk;
            junk = sample_item(16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA);
            junk.func = FUNC_RESERVED;
            junk.src_index = 2'd3;
            junk.dst_index = 2'd3;
            junk.new_gain = 16'hFFFF;
            pending_items.push_back(junk);
        end
        // half gain on input 0: +0.5 LSB rounds up, -0.5 LSB rounds to zero
        pending_items.push_back(gain_cmd(FUNC_SET_INPLACE, 2'd0, 2'd0, 16'h2000));
        pending_items.push_back(sample_item(16'sd1, 16'sd3, -16'sd1, -16'sd3));
        pending_items.push_back(sample_item(-16'sd1, 16'sd0, 16'sd1, 16'sh7FFF));

        // Largest default gain, every crosspoint routed
        new_setting(16'hFFFF, 16'hFFFF);
        pending_items.push_back(sample_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
        pending_items.push_back(gain_cmd(FUNC_SET_INPLACE, 2'd1, 2'd0, 16'h0000));
        pending_items.push_back(gain_cmd(FUNC_SET_INPLACE, 2'd2, 2'd1, 16'hFFFF));
        pending_items.push_back(gain_cmd(FUNC_SET_CROSS, 2'd0, 2'd0, 16'h0000));
        pending_items.push_back(gain_cmd(FUNC_SET_CROSS, 2'd1, 2'd2, 16'h4000));
        pending_items.push_back(gain_cmd(FUNC_SET_CROSS, 2'd3, 2'd1, 16'hFFFF));
        pending_items.push_back(sample_item(16'sd100, -16'sd200, 16'sd300, 16'sh8000));
        pending_items.push_back(sample_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        pending_items.push_back(sample_item(-16'sd1, -16'sd1, -16'sd1, -16'sd1));
        pending_items.push_back(gain_cmd(FUNC_RESERVED, 2'd2, 2'd1, 16'h1234));

        // Route removal leaves stored gains in place but silent
        new_setting(16'h4000, 16'h8421);
        pending_items.push_back(sample_item(16'sh7FFF, 16'sh8000, 16'sd12345, -16'sd12345));
        random_burst(RAND_PER_SETTING);

        // Zero default, full routing
        new_setting(16'h0000, 16'hFFFF);
        random_burst(RAND_PER_SETTING);

        new_setting(rand_gain(), 16'($urandom));
        random_burst(RAND_PER_SETTING);

        // Everything unrouted: every crosspoint command is refused
        new_setting(16'hFFFF, 16'h0000);
        random_burst(RAND_PER_SETTING);

        new_setting(gain_t'($urandom), 16'($urandom));
        random_burst(RAND_PER_SETTING);

        new_setting(16'h2000, 16'hFFFF);
        random_burst(RAND_PER_SETTING);

        wait_quiet();
        if (expected_mix.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_mix.size());
            err_count++;
        end

        $display("Covered %0d sample positions, %0d gain updates, %0d refused transactions",
                 n_done, n_updated, n_refused);
        $display("across %0d register settings in %0d cycles", n_settings, cycle_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/agmm_pkg.sv
rtl/agmm_scale_lane.sv
rtl/agmm_mix_lane.sv
rtl/audio_gain_matrix_mixer_top.sv
test/tb_audio_gain_matrix_mixer_top.sv
